/* hdl/afd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package afd_pkg;

  // Q2.14 coefficients
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 14;

  // configuration port
  localparam int RSZ_W      = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_RING_SIZE = 2'd0;
  localparam cfg_addr_t CFG_OUT_GAIN  = 2'd1;
  localparam cfg_addr_t CFG_FEED_COEF = 2'd2;

  localparam logic [RSZ_W-1:0]         RING_SIZE_RST = 4'd12;
  localparam logic signed [COEF_W-1:0] OUT_GAIN_RST  = 16'sd16384;
  localparam logic signed [COEF_W-1:0] FEED_COEF_RST = 16'sd8192;

  // access request to the ring memory
  typedef struct packed {
    logic rd;
    logic wr;
  } ring_req_t;

endpackage

`default_nettype wire

/* hdl/afd_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface afd_in_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface afd_out_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface afd_cfg_if
  import afd_pkg::*;
();
  logic                  valid;
  logic                  ready;
  cfg_addr_t             addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

/* hdl/afd_ring.sv */
`timescale 1ns / 1ps
`default_nettype none

module afd_ring
  import afd_pkg::*;
#(
  parameter int DepthLog2 = 12,
  parameter int Width     = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ring_req_t            req_i,
  input  wire logic [DepthLog2-1:0] addr_i,
  input  wire logic [Width-1:0]     wdata_i,
  output logic [Width-1:0]          rdata_o,
  output logic                      busy_o
);

  logic [Width-1:0]     mem [2**DepthLog2];
  logic [DepthLog2-1:0] clr_addr_q;
  logic                 busy_q;
  logic                 we;
  logic [DepthLog2-1:0] waddr;
  logic [Width-1:0]     wdata;
  logic [Width-1:0]     rdata_q;

  // zero sweep after reset, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    if (busy_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = '0;
    end else begin
      we    = req_i.wr;
      waddr = addr_i;
      wdata = wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd && !busy_q) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

/* hdl/allpass_delay_filter.sv */
`timescale 1ns / 1ps
`default_nettype none

// one word at a time: the ring read, two multiply stages and the ring write-back
//   run in sequence for each word (ST_MUL1, ST_MUL2, ST_WB); ST_WB sets the output
//   word valid, and holds while the previous output word still waits
// reset: registers return to their reset values, then a zero sweep clears all
//   2**RING_DEPTH_LOG2 ring entries (4096 by default); no input word is taken
//   meanwhile, configuration writes are taken at all times

module allpass_delay_filter
  import afd_pkg::*;
#(
  parameter int RING_DEPTH_LOG2 = 12,
  parameter int SAMPLE_WIDTH    = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  afd_cfg_if.sink   cfg_i,
  afd_in_if.sink    in_i,
  afd_out_if.source out_o
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int DL  = RING_DEPTH_LOG2;
  localparam int FW  = SW + 2;             // rounded product
  localparam int DW  = SW + 3;             // difference, output sum
  localparam int P1W = COEF_W + SW;
  localparam int P2W = COEF_W + DW;
  localparam int BW  = P2W - COEF_FRAC;    // rounded feedback product
  localparam int WW  = BW + 1;             // feedback plus input

  localparam logic signed [P1W-1:0] RND1 = P1W'(2**(COEF_FRAC-1));
  localparam logic signed [P2W-1:0] RND2 = P2W'(2**(COEF_FRAC-1));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_WB
  } state_e;

  function automatic logic signed [SW-1:0] sat_sample(input logic signed [WW-1:0] v);
    logic [WW-SW:0] hi_bits;
    hi_bits = v[WW-1:SW-1];
    if (hi_bits == '0 || hi_bits == '1) begin
      return v[SW-1:0];
    end else if (v[WW-1]) begin
      return {1'b1, {(SW-1){1'b0}}};
    end else begin
      return {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  // configuration
  logic [RSZ_W-1:0]         ring_size_q;
  logic signed [COEF_W-1:0] out_gain_q;
  logic signed [COEF_W-1:0] feed_coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q <= RING_SIZE_RST;
      out_gain_q  <= OUT_GAIN_RST;
      feed_coef_q <= FEED_COEF_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        CFG_RING_SIZE: ring_size_q <= cfg_i.wdata[RSZ_W-1:0];
        CFG_OUT_GAIN:  out_gain_q  <= cfg_i.wdata;
        CFG_FEED_COEF: feed_coef_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // datapath and control registers
  state_e                state_q;
  logic signed [SW-1:0]  x_q;
  logic [DL-1:0]         slot_q;
  logic [DL-1:0]         widx_q;
  logic signed [SW-1:0]  held_q;
  logic signed [FW-1:0]  feed_q;
  logic signed [FW-1:0]  gp_q;
  logic signed [SW-1:0]  wr_q;
  logic signed [SW-1:0]  y_q;
  logic                  out_valid_q;
  logic signed [SW-1:0]  out_data_q;

  logic                  ring_busy;
  logic [SW-1:0]         ring_rdata;
  ring_req_t             ring_req;
  logic [DL-1:0]         ring_addr;
  logic [DL-1:0]         mask;
  logic [DL-1:0]         slot_d;
  logic                  in_fire;
  logic                  out_free;

  logic signed [P1W-1:0] p_feed;
  logic signed [P1W-1:0] p_feed_r;
  logic signed [FW-1:0]  feed_d;
  logic signed [P1W-1:0] p_gain;
  logic signed [P1W-1:0] p_gain_r;
  logic signed [FW-1:0]  gp_d;
  logic signed [DW-1:0]  diff;
  logic signed [P2W-1:0] p_fb;
  logic signed [P2W-1:0] p_fb_r;
  logic signed [BW-1:0]  fb;
  logic signed [WW-1:0]  wsum;
  logic signed [DW-1:0]  ysum;

  // active ring mask, sizes beyond the depth use the whole ring
  always_comb begin
    for (int i = 0; i < DL; i++) begin
      mask[i] = ((RSZ_W+1)'(i) < {1'b0, ring_size_q});
    end
  end

  assign slot_d   = widx_q & mask;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    p_feed   = P1W'(feed_coef_q) * P1W'(x_q);
    p_feed_r = p_feed + RND1;
    feed_d   = p_feed_r[P1W-1:COEF_FRAC];

    p_gain   = P1W'(out_gain_q) * P1W'(held_q);
    p_gain_r = p_gain + RND1;
    gp_d     = p_gain_r[P1W-1:COEF_FRAC];

    diff     = DW'(held_q) - DW'(feed_q);
    p_fb     = P2W'(feed_coef_q) * P2W'(diff);
    p_fb_r   = p_fb + RND2;
    fb       = p_fb_r[P2W-1:COEF_FRAC];
    wsum     = WW'(fb) + WW'(x_q);

    ysum     = DW'(gp_q) - DW'(feed_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      slot_q      <= '0;
      widx_q      <= '0;
      held_q      <= '0;
      feed_q      <= '0;
      gp_q        <= '0;
      wr_q        <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // the write-back state sets valid itself when it hands over a word
      if (out_valid_q && out_o.ready && state_q != ST_WB) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            x_q     <= in_i.sample_in;
            slot_q  <= slot_d;
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          feed_q  <= feed_d;
          gp_q    <= gp_d;
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          wr_q    <= sat_sample(wsum);
          y_q     <= sat_sample(WW'(ysum));
          state_q <= ST_WB;
        end
        ST_WB: begin
          // hold here while the previous output word is still waiting
          if (out_free) begin
            held_q      <= ring_rdata;
            widx_q      <= widx_q + 1'b1;
            out_data_q  <= y_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE) && !ring_busy;

  assign ring_req.rd = in_fire;
  assign ring_req.wr = (state_q == ST_WB) && out_free;
  assign ring_addr   = in_fire ? slot_d : slot_q;

  afd_ring #(
    .DepthLog2 (DL),
    .Width     (SW)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ring_req),
    .addr_i  (ring_addr),
    .wdata_i (wr_q),
    .rdata_o (ring_rdata),
    .busy_o  (ring_busy)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

endmodule

`default_nettype wire

/* tb/sv/allpass_out_checker.sv */
`timescale 1ns / 1ps

module allpass_out_checker
  import afd_pkg::*;
#(
  parameter int RING_DEPTH_LOG2 = 12,
  parameter int SAMPLE_WIDTH    = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  afd_cfg_if        cfg_w,
  afd_in_if         in_w,
  afd_out_if        out_w,
  output int        fail_count_o,
  output int        word_count_o
);

  localparam int     RING_ENTRIES = 1 << RING_DEPTH_LOG2;
  localparam longint SAMPLE_MAX   = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam longint SAMPLE_MIN   = -SAMPLE_MAX - 64'sd1;
  localparam int     SHOWN_ERRORS = 10;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  sample_t                     ring_q [RING_ENTRIES];
  logic [RING_DEPTH_LOG2-1:0]  wr_idx;
  sample_t                     held;
  logic [RSZ_W-1:0]            ring_log2;
  logic signed [COEF_W-1:0]    gain;
  logic signed [COEF_W-1:0]    coef;
  sample_t                     want_samples [$];
  int                          fails;
  int                          words;

  // q2.14 product, round half up
  function automatic longint q14_round(longint c, longint v);
    return (c * v + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  function automatic longint clamp_sample(longint v);
    if (v > SAMPLE_MAX) begin
      return SAMPLE_MAX;
    end
    if (v < SAMPLE_MIN) begin
      return SAMPLE_MIN;
    end
    return v;
  endfunction

  // advances the section by one input word and returns the filtered word
  function automatic sample_t filtered_sample(sample_t s);
    int     n;
    int     slot;
    longint x;
    longint prev;
    longint feed;
    longint wr;
    longint y;
    n    = (int'(ring_log2) > RING_DEPTH_LOG2) ? RING_DEPTH_LOG2 : int'(ring_log2);
    slot = int'(wr_idx) & ((1 << n) - 1);
    x    = longint'(s);
    prev = longint'(held);
    feed = q14_round(longint'(coef), x);
    wr   = clamp_sample(q14_round(longint'(coef), prev - feed) + x);
    held = ring_q[slot];
    ring_q[slot] = sample_t'(wr);
    wr_idx = wr_idx + 1'b1;
    y = clamp_sample(q14_round(longint'(gain), prev) - feed);
    return sample_t'(y);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RING_ENTRIES; i++) begin
        ring_q[i] = '0;
      end
      wr_idx    = '0;
      held      = '0;
      ring_log2 = RING_SIZE_RST;
      gain      = OUT_GAIN_RST;
      coef      = FEED_COEF_RST;
      want_samples.delete();
      fails = 0;
      words = 0;
      fail_count_o <= 0;
      word_count_o <= 0;
    end else begin : watch
      sample_t want;
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_w.addr)
          CFG_RING_SIZE: begin
            ring_log2 = cfg_w.wdata[RSZ_W-1:0];
          end
          CFG_OUT_GAIN: begin
            gain = cfg_w.wdata;
          end
          CFG_FEED_COEF: begin
            coef = cfg_w.wdata;
          end
          default: begin
          end
        endcase
      end
      if (in_w.valid && in_w.ready) begin
        want_samples.push_back(filtered_sample(in_w.sample_in));
      end
      if (out_w.valid && out_w.ready) begin
        if (want_samples.size() == 0) begin
          if (fails < SHOWN_ERRORS) begin
            $display("unexpected output word %0d: got %0d", words, out_w.sample_out);
          end
          fails++;
        end else begin
          want = want_samples.pop_front();
          if (out_w.sample_out !== want) begin
            if (fails < SHOWN_ERRORS) begin
              $display("sample_out mismatch at word %0d: expected %0d, got %0d",
                       words, want, out_w.sample_out);
            end
            fails++;
          end
        end
        words++;
      end
      fail_count_o <= fails;
      word_count_o <= words;
    end
  end

endmodule

/* tb/sv/allpass_delay_filter_tb.sv */
`timescale 1ns / 1ps

module allpass_delay_filter_tb;
  import afd_pkg::*;

  localparam int        SAMPLE_W      = 16;
  localparam int        RST_CYCLES    = 7;
  localparam int        CYCLE_LIMIT   = 400000;
  localparam int        RANDOM_PHASES = 9;
  localparam int        PHASE_WORDS   = 89;
  localparam int        HOLD_PHASE    = 2;
  localparam int        HOLD_CYCLES   = 300;
  localparam int        DRAIN_CYCLES  = 16;
  localparam cfg_addr_t CFG_UNUSED    = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t DIRECTED_WORDS [24] = '{
    16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'sh7fff, 16'sh7fff, 16'sh8000,
    16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff, 16'sh0000, 16'sh8000,
    16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh5555, 16'shaaaa, 16'sh7fff, 16'sh8000
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   tx_idle;
  bit   rx_idle;
  int   hold_ask;
  int   hold_seen;
  int   sent_words;
  int   setting_count;
  int   fail_count;
  int   word_count;
  int   cycle_count;

  afd_cfg_if                 cfg_w ();
  afd_in_if  #(.W(SAMPLE_W)) in_w ();
  afd_out_if #(.W(SAMPLE_W)) out_w ();

  allpass_delay_filter u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_w),
    .in_i  (in_w),
    .out_o (out_w)
  );

  allpass_out_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_w       (cfg_w),
    .in_w        (in_w),
    .out_w       (out_w),
    .fail_count_o(fail_count),
    .word_count_o(word_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("allpass_delay_filter test failed");
      $finish;
    end
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      1: return sample_t'($urandom_range(0, 511) - 256);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coef();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000;
      3: return 16'hc000;
      4: return 16'h0000;
      5: return 16'($urandom_range(0, 32767));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [RSZ_W-1:0] pick_ring_log2();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return RSZ_W'($urandom_range(0, 4));
      5: return RSZ_W'($urandom_range(5, 11));
      6: return 4'd12;
      7: return RSZ_W'($urandom_range(13, 15));
      default: return RSZ_W'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic cfg_write(cfg_addr_t a, logic [CFG_DATA_W-1:0] d);
    cfg_w.valid <= 1'b1;
    cfg_w.addr  <= a;
    cfg_w.wdata <= d;
    do @(posedge clk_i); while (!cfg_w.ready);
    cfg_w.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // valid stays high into the next word unless a gap is drawn
  task automatic send_word(sample_t s);
    in_w.valid     <= 1'b1;
    in_w.sample_in <= s;
    do @(posedge clk_i); while (!in_w.ready);
    sent_words++;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_w.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_w.valid <= 1'b0;
    while (word_count != sent_words) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_filter(logic [RSZ_W-1:0] rl, logic [CFG_DATA_W-1:0] g,
                            logic [CFG_DATA_W-1:0] c);
    // upper bits of the ring size word are don't care
    cfg_write(CFG_RING_SIZE, {12'($urandom()), rl});
    cfg_write(CFG_OUT_GAIN, g);
    cfg_write(CFG_FEED_COEF, c);
    setting_count++;
  endtask

  initial begin
    out_w.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        out_w.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          @(posedge clk_i);
        end
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_w.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_w.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_w.valid    <= 1'b0;
    cfg_w.addr     <= CFG_RING_SIZE;
    cfg_w.wdata    <= '0;
    in_w.valid     <= 1'b0;
    in_w.sample_in <= '0;
    sent_words     = 0;
    setting_count  = 1;
    hold_ask       = 0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, full ring, sample extremes
    for (int i = 0; i < 8; i++) begin
      send_word(DIRECTED_WORDS[i]);
    end
    drain();

    // one-entry ring, maximum coefficient, most negative gain, write to an unused index
    set_filter(4'd0, 16'h8000, 16'h7fff);
    cfg_write(CFG_UNUSED, 16'($urandom()));
    for (int i = 8; i < 16; i++) begin
      send_word(DIRECTED_WORDS[i]);
    end
    drain();

    // ring size above the depth, most negative coefficient, maximum gain
    set_filter(4'd15, 16'h7fff, 16'h8000);
    for (int i = 16; i < 24; i++) begin
      send_word(DIRECTED_WORDS[i]);
    end
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_filter(pick_ring_log2(), pick_coef(), pick_coef());
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(CFG_UNUSED, 16'($urandom()));
      end
      tx_idle = (p != HOLD_PHASE) && (p != RANDOM_PHASES - 1);
      rx_idle = (p != RANDOM_PHASES - 1);
      if (p == HOLD_PHASE) begin
        hold_ask++;
      end
      for (int w = 0; w < PHASE_WORDS; w++) begin
        send_word(pick_sample());
      end
      drain();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d input words through %0d filter settings, ring sizes 0 to 15,",
             sent_words, setting_count);
    $display("saturating gains and coefficients, one long output stall; %0d words checked",
             word_count);
    if (fail_count == 0) begin
      $display("allpass_delay_filter test passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("allpass_delay_filter test failed");
    end
    $finish;
  end

endmodule
